[rtl/sdeb_pkg.sv]
`timescale 1ns / 1ps

package sdeb_pkg;

    // Default counter widths handed to the top level parameters.
    localparam int TIMER_BITS_DEF = 16;
    localparam int AGREE_BITS_DEF = 8;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Fixed field widths.
    localparam int INTERVAL_W = 16;
    localparam int DELAY_W    = 16;
    localparam int REQ_W      = 8;
    localparam int TICKS_W    = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_AGREE  = 2'd2;

    // Register reset values.
    localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 16'd10;
    localparam logic [DELAY_W-1:0]    HOLD_DELAY_RST      = 16'd50;
    localparam logic [REQ_W-1:0]      REQUIRED_AGREE_RST  = 8'd3;

    // Current configuration as seen by the debounce core.
    typedef struct packed {
        logic [INTERVAL_W-1:0] sample_interval;
        logic [DELAY_W-1:0]    hold_delay;
        logic [REQ_W-1:0]      required_agreements;
    } t_cfg;

    // One result beat.
    typedef struct packed {
        logic               debounced_level;
        logic               rising_edge;
        logic               falling_edge;
        logic [TICKS_W-1:0] ticks_since_change;
    } t_result;

endpackage

[rtl/sdeb_cfg.sv]
`timescale 1ns / 1ps

module sdeb_cfg
    import sdeb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; an index past the register list is dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_INTERVAL: n_cfg.sample_interval     = i_cfg_data;
                CFG_HOLD_DELAY:      n_cfg.hold_delay          = i_cfg_data;
                CFG_REQUIRED_AGREE:  n_cfg.required_agreements = i_cfg_data[REQ_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_interval     <= SAMPLE_INTERVAL_RST;
            r_cfg.hold_delay          <= HOLD_DELAY_RST;
            r_cfg.required_agreements <= REQUIRED_AGREE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/sdeb_core.sv]
`timescale 1ns / 1ps

module sdeb_core
    import sdeb_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int AGREE_BITS = AGREE_BITS_DEF
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_raw_level,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    // Compare widths cover both the counter and the register it meets.
    localparam int TW = (TIMER_BITS > INTERVAL_W) ? TIMER_BITS : INTERVAL_W;
    localparam int AW = (AGREE_BITS > REQ_W) ? AGREE_BITS : REQ_W;
    localparam logic [TW-1:0] TICKS_MAX = TW'({TICKS_W{1'b1}});

    logic [TIMER_BITS-1:0] r_ticks_since_sample, n_ticks_since_sample;
    logic [TIMER_BITS-1:0] r_change_timer, n_change_timer;
    logic [AGREE_BITS-1:0] r_agree_count, n_agree_count;
    logic                  r_last_sample, n_last_sample;
    logic                  r_stable_level, n_stable_level;

    logic [TIMER_BITS-1:0] sample_inc;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [AGREE_BITS-1:0] agree_inc;
    logic                  sample_hit;
    logic                  differs;
    logic                  accept_level;

    // Saturating advances of the two tick counters and the agreement count.
    assign sample_inc = (r_ticks_since_sample == '1) ? r_ticks_since_sample
                                                     : r_ticks_since_sample + 1'b1;
    assign timer_inc  = (r_change_timer == '1) ? r_change_timer : r_change_timer + 1'b1;
    assign agree_inc  = (r_agree_count == '1) ? r_agree_count : r_agree_count + 1'b1;

    assign sample_hit = TW'(sample_inc) >= TW'(i_cfg.sample_interval);
    assign differs    = i_raw_level != r_last_sample;

    // Sample, track agreement and decide on the debounced level.
    always_comb begin
        n_ticks_since_sample = sample_hit ? '0 : sample_inc;
        n_change_timer       = (sample_hit && differs) ? '0 : timer_inc;
        n_last_sample        = (sample_hit && differs) ? i_raw_level : r_last_sample;
        if (sample_hit) begin
            n_agree_count = differs ? '0 : agree_inc;
        end else begin
            n_agree_count = r_agree_count;
        end
        accept_level   = sample_hit
                         && (TW'(n_change_timer) > TW'(i_cfg.hold_delay))
                         && (AW'(n_agree_count) >= AW'(i_cfg.required_agreements));
        n_stable_level = accept_level ? i_raw_level : r_stable_level;
    end

    // The stored level doubles as the previous level for edge detection.
    always_comb begin
        o_result.debounced_level    = n_stable_level;
        o_result.rising_edge        = n_stable_level & ~r_stable_level;
        o_result.falling_edge       = ~n_stable_level & r_stable_level;
        o_result.ticks_since_change = (TW'(n_change_timer) > TICKS_MAX)
                                      ? {TICKS_W{1'b1}}
                                      : TICKS_W'(TW'(n_change_timer));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_since_sample <= '0;
            r_change_timer       <= '0;
            r_agree_count        <= '0;
            r_last_sample        <= 1'b0;
            r_stable_level       <= 1'b0;
        end else if (i_step) begin
            r_ticks_since_sample <= n_ticks_since_sample;
            r_change_timer       <= n_change_timer;
            r_agree_count        <= n_agree_count;
            r_last_sample        <= n_last_sample;
            r_stable_level       <= n_stable_level;
        end
    end

endmodule

[rtl/sampled_debouncer_with_edges_top.sv]
`timescale 1ns / 1ps

// Switch debouncer driven by one input beat per millisecond tick. Every
// sample interval the raw level is sampled; the debounced level follows it
// only once the time since the last sampled change exceeds the debounce delay
// and enough agreeing samples have been seen. Each tick beat yields one
// result beat with the debounced level, one-tick rising and falling edge
// flags and the saturating tick count since the last sampled change. The block
// takes one beat per cycle while input stall is low, and each result is
// registered in the output register; a two-entry output buffer (output
// register plus skid register) keeps input beats flowing while a result
// waits, and input stall rises only when both entries are full.
// Configuration writes are always ready and take effect on the next tick.
module sampled_debouncer_with_edges_top
    import sdeb_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int AGREE_BITS = AGREE_BITS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_raw_level,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_debounced_level,
    output logic                  o_rising_edge,
    output logic                  o_falling_edge,
    output logic [TICKS_W-1:0]    o_ticks_since_change,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_result result;
    logic    in_fire;
    logic    out_free;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_cfg_ready = 1'b1;

    sdeb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sdeb_core #(
        .TIMER_BITS (TIMER_BITS),
        .AGREE_BITS (AGREE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_fire),
        .i_raw_level (i_raw_level),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    // Input is taken whenever the skid entry is empty.
    assign o_in_stall = r_skid_valid;
    assign in_fire    = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Output register fed from the skid entry first, then from the core.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (in_fire) begin
            r_skid <= result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_debounced_level    = r_out.debounced_level;
    assign o_rising_edge        = r_out.rising_edge;
    assign o_falling_edge       = r_out.falling_edge;
    assign o_ticks_since_change = r_out.ticks_since_change;

endmodule

[bench/sampled_debouncer_with_edges_top_tb.sv]
`timescale 1ns / 1ps

module sampled_debouncer_with_edges_top_tb;
    import sdeb_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 150;
    localparam int HOLDOFF_LEN   = 300;

    // Index 3 decodes to no register at all.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic [TICKS_W-1:0]   TICKS_MAX      = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_raw_level;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_debounced_level;
    logic                  o_rising_edge;
    logic                  o_falling_edge;
    logic [TICKS_W-1:0]    o_ticks_since_change;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sampled_debouncer_with_edges_top DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_raw_level          (i_raw_level),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_debounced_level    (o_debounced_level),
        .o_rising_edge        (o_rising_edge),
        .o_falling_edge       (o_falling_edge),
        .o_ticks_since_change (o_ticks_since_change),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // Configuration as the block should currently hold it.
    logic [INTERVAL_W-1:0] interval_cfg = SAMPLE_INTERVAL_RST;
    logic [DELAY_W-1:0]    delay_cfg    = HOLD_DELAY_RST;
    logic [REQ_W-1:0]      agree_cfg    = REQUIRED_AGREE_RST;

    // Debounce state mirrored from the block, all cleared by reset.
    logic [TIMER_BITS_DEF-1:0] sample_ctr   = '0;
    logic [TIMER_BITS_DEF-1:0] since_change = '0;
    logic                      sampled_raw  = 1'b0;
    logic [AGREE_BITS_DEF-1:0] agree_ctr    = '0;
    logic                      level_q      = 1'b0;
    logic                      level_d1     = 1'b0;

    t_result     pending_results[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          tx_idle_en     = 1'b1;
    bit          rx_idle_en     = 1'b1;
    int unsigned hold_req       = 0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Advance the debouncer by one tick and return the result beat it yields.
    function automatic t_result debounce_tick(input logic raw);
        t_result res;
        if (sample_ctr != '1) sample_ctr = sample_ctr + 1'b1;
        if (since_change != '1) since_change = since_change + 1'b1;
        if (sample_ctr >= interval_cfg) begin
            sample_ctr = '0;
            if (raw != sampled_raw) begin
                since_change = '0;
                agree_ctr    = '0;
                sampled_raw  = raw;
            end else if (agree_ctr != '1) begin
                agree_ctr = agree_ctr + 1'b1;
            end
            if (since_change > delay_cfg && agree_ctr >= agree_cfg) level_q = raw;
        end
        res.debounced_level    = level_q;
        res.rising_edge        = level_q & ~level_d1;
        res.falling_edge       = ~level_q & level_d1;
        res.ticks_since_change = (since_change > TICKS_MAX) ? TICKS_MAX
                                                            : TICKS_W'(since_change);
        level_d1 = level_q;
        return res;
    endfunction

    // Idle length: mostly short, now and then a long pause.
    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one tick beat, wait for it to be taken, then maybe go idle.
    task automatic send_tick(input logic raw);
        int unsigned gap;
        i_in_valid  <= 1'b1;
        i_raw_level <= raw;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(debounce_tick(raw));
        gap = (tx_idle_en && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering ticks and wait until every result beat has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One register write; valid stays up when another write follows directly.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (last) i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SAMPLE_INTERVAL: interval_cfg = data[INTERVAL_W-1:0];
            CFG_HOLD_DELAY:      delay_cfg    = data[DELAY_W-1:0];
            CFG_REQUIRED_AGREE:  agree_cfg    = data[REQ_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [INTERVAL_W-1:0] interval,
                              input logic [DELAY_W-1:0] delay,
                              input logic [CFG_DATA_W-1:0] agree_word);
        write_reg(CFG_SAMPLE_INTERVAL, interval, 1'b0);
        write_reg(CFG_HOLD_DELAY, delay, 1'b0);
        write_reg(CFG_REQUIRED_AGREE, agree_word, 1'b1);
    endtask

    // A few ticks under the reset configuration.
    task automatic test_reset_values();
        logic [5:0] pattern;
        int i;
        pattern = 6'b001011;
        for (i = 0; i < 6; i++) send_tick(pattern[i]);
        drain();
    endtask

    // Zero interval samples on every tick; zero agreements leaves only the
    // time condition. The upper data byte must be dropped by the agreement
    // register.
    task automatic test_every_tick_sampling();
        logic [7:0] pattern;
        int i;
        set_config(16'd0, 16'd0, 16'hAB00);
        pattern = 8'b10011011;
        for (i = 0; i < 8; i++) send_tick(pattern[i]);
        drain();
    endtask

    // A write to the unused index changes nothing.
    task automatic test_register_decode();
        logic [4:0] pattern;
        int i;
        write_reg(CFG_UNUSED_IDX, 16'hFFFF, 1'b0);
        write_reg(CFG_REQUIRED_AGREE, 16'h5A02, 1'b1);
        pattern = 5'b11000;
        for (i = 0; i < 5; i++) send_tick(pattern[i]);
        drain();
    endtask

    // Largest interval takes no sample; largest delay is never exceeded.
    task automatic test_config_extremes();
        int i;
        set_config(16'hFFFF, 16'd0, 16'd0);
        for (i = 0; i < 3; i++) send_tick(1'b1);
        drain();
        set_config(16'd1, 16'hFFFF, 16'd0);
        for (i = 0; i < 4; i++) send_tick(i[0]);
        drain();
    endtask

    // Receiver holds off for a long stretch while ticks keep coming, so the
    // output buffer fills and the input stalls.
    task automatic test_output_holdoff();
        int i;
        set_config(16'd2, 16'd4, 16'd1);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req   = HOLDOFF_LEN;
        for (i = 0; i < 40; i++) send_tick(1'($urandom_range(0, 1)));
        drain();
    endtask

    // Random settings, each phase driving level runs long enough to settle
    // with short glitches mixed in.
    task automatic test_random_streams();
        int phase;
        int sent;
        int run_len;
        int settle;
        int k;
        int unsigned roll;
        logic lvl;
        logic [INTERVAL_W-1:0] interval;
        logic [DELAY_W-1:0] delay;
        logic [REQ_W-1:0] agree;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            tx_idle_en = (phase % 3) != 0;
            rx_idle_en = (phase % 4) != 0;
            roll = $urandom_range(0, 9);
            interval = (roll < 7) ? INTERVAL_W'($urandom_range(0, 4)) :
                       (roll < 9) ? INTERVAL_W'($urandom_range(5, 30)) :
                                    INTERVAL_W'($urandom);
            roll = $urandom_range(0, 9);
            delay = (roll < 7) ? DELAY_W'($urandom_range(0, 15)) :
                    (roll < 9) ? DELAY_W'($urandom_range(16, 200)) :
                                 DELAY_W'($urandom);
            agree = ($urandom_range(0, 4) != 0) ? REQ_W'($urandom_range(0, 6))
                                                : REQ_W'($urandom);
            set_config(interval, delay, {8'($urandom_range(0, 255)), agree});
            settle = (int'(interval_cfg) + 1) * (int'(agree_cfg) + 2)
                     + int'(delay_cfg) + 2;
            if (settle > 150) settle = 150;
            sent = 0;
            lvl  = 1'($urandom_range(0, 1));
            while (sent < PHASE_TICKS) begin
                if ($urandom_range(0, 99) < 25) begin
                    run_len = $urandom_range(1, 3);
                    for (k = 0; k < run_len; k++) send_tick(~lvl);
                end else begin
                    lvl     = ~lvl;
                    run_len = $urandom_range(1, settle);
                    for (k = 0; k < run_len; k++) send_tick(lvl);
                end
                sent += run_len;
            end
            drain();
        end
    endtask

    // Receiver stall: random pauses, or a long hold-off on request.
    initial begin : out_stall_gen
        int unsigned stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len();
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted result beat with the oldest expected one.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: debounced_level %0b ticks_since_change %0d",
                       o_debounced_level, o_ticks_since_change);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_debounced_level !== want.debounced_level) begin
                    $error("debounced_level: expected %0b, actual %0b",
                           want.debounced_level, o_debounced_level);
                    mismatch_count++;
                end
                if (o_rising_edge !== want.rising_edge) begin
                    $error("rising_edge: expected %0b, actual %0b",
                           want.rising_edge, o_rising_edge);
                    mismatch_count++;
                end
                if (o_falling_edge !== want.falling_edge) begin
                    $error("falling_edge: expected %0b, actual %0b",
                           want.falling_edge, o_falling_edge);
                    mismatch_count++;
                end
                if (o_ticks_since_change !== want.ticks_since_change) begin
                    $error("ticks_since_change: expected %0d, actual %0d",
                           want.ticks_since_change, o_ticks_since_change);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sampled_debouncer_with_edges_top verification failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_raw_level <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SAMPLE_INTERVAL;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_every_tick_sampling();
        test_register_decode();
        test_config_extremes();
        test_output_holdoff();
        test_random_streams();

        // Let any stray beat show up before the verdict.
        rx_idle_en = 1'b0;
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("sampled_debouncer_with_edges_top verification clean");
        end else begin
            $display("sampled_debouncer_with_edges_top verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/sdeb_pkg.sv
rtl/sdeb_cfg.sv
rtl/sdeb_core.sv
rtl/sampled_debouncer_with_edges_top.sv
bench/sampled_debouncer_with_edges_top_tb.sv
